// File: rtl/core/serial_packet_deframer_macros.svh
// Assertion macros for the checks in the top-level file.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SERIAL_PACKET_DEFRAMER_MACROS_SVH
`define SERIAL_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication: whenever trig holds, expect holds too.
`define SPD_ASSERT_NOW(label, trig, expect_c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expect_c)) \
		else $error("serial_packet_deframer: same-cycle check failed");

// Next-cycle implication: whenever trig holds, expect holds in the next cycle.
`define SPD_ASSERT_NEXT(label, trig, expect_c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expect_c)) \
		else $error("serial_packet_deframer: next-cycle check failed");

`endif

// File: rtl/core/spd_pkg.sv
package spd_pkg;

	localparam int PAYLOAD_MAX = 32;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = $clog2(PAYLOAD_MAX);
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_FIELDS_W = BYTE_W + LEN_W + 1 + 1 + IDX_W + BYTE_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'hAA;
	localparam logic [BYTE_W-1:0] TRAILER_RST       = 8'h45;
	localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST  = 6'd32;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_MASK  = 8'hFE;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST   = 2'd0,
		REG_SYNC_SECOND  = 2'd1,
		REG_TRAILER      = 2'd2,
		REG_LENGTH_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SYNC1   = 3'd1,
		PH_SYNC2   = 3'd2,
		PH_TYPE    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_TRAILER = 3'd5,
		PH_EMIT_RD = 3'd6,
		PH_EMIT_LD = 3'd7
	} phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_sync1;
		logic cap_sync2;
		logic cap_type;
		logic cap_length;
		logic pay_wr;
		logic idx_clr;
		logic rd_en;
		logic ld_out;
		logic idx_inc;
	} spd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sync_hit;
		logic hdr_ok;
		logic len_zero;
		logic pay_done;
		logic trailer_hit;
		logic held_zero;
		logic last_item;
		logic out_free;
	} spd_stat_t;

endpackage

// File: rtl/core/spd_ram.sv
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/spd_ctrl.sv
module spd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spd_pkg::spd_stat_t st,
	output spd_pkg::spd_cmd_t  cmd
);

	spd_pkg::phase_t phase_q, phase_d;
	logic            take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spd_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	assign in_ready = (phase_q != spd_pkg::PH_EMIT_RD) && (phase_q != spd_pkg::PH_EMIT_LD);
	assign take     = in_valid && in_ready;

	// Next state.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			spd_pkg::PH_IDLE: begin
				if (take) phase_d = st.sync_hit ? spd_pkg::PH_SYNC1 : spd_pkg::PH_IDLE;
			end
			spd_pkg::PH_SYNC1: begin
				if (take) phase_d = spd_pkg::PH_SYNC2;
			end
			spd_pkg::PH_SYNC2: begin
				if (take) phase_d = spd_pkg::PH_TYPE;
			end
			spd_pkg::PH_TYPE: begin
				if (take) begin
					if (!st.hdr_ok) phase_d = spd_pkg::PH_IDLE;
					else if (st.len_zero) phase_d = spd_pkg::PH_TRAILER;
					else phase_d = spd_pkg::PH_PAYLOAD;
				end
			end
			spd_pkg::PH_PAYLOAD: begin
				if (take && st.pay_done) phase_d = spd_pkg::PH_TRAILER;
			end
			spd_pkg::PH_TRAILER: begin
				if (take) begin
					if (!st.trailer_hit) phase_d = spd_pkg::PH_IDLE;
					else if (st.held_zero) phase_d = spd_pkg::PH_EMIT_LD;
					else phase_d = spd_pkg::PH_EMIT_RD;
				end
			end
			spd_pkg::PH_EMIT_RD: begin
				phase_d = spd_pkg::PH_EMIT_LD;
			end
			spd_pkg::PH_EMIT_LD: begin
				if (st.out_free) phase_d = st.last_item ? spd_pkg::PH_IDLE : spd_pkg::PH_EMIT_RD;
			end
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		unique case (phase_q)
			spd_pkg::PH_IDLE:    cmd.cap_sync1  = take;
			spd_pkg::PH_SYNC1:   cmd.cap_sync2  = take;
			spd_pkg::PH_SYNC2:   cmd.cap_type   = take;
			spd_pkg::PH_TYPE:    cmd.cap_length = take && st.hdr_ok;
			spd_pkg::PH_PAYLOAD: cmd.pay_wr     = take;
			spd_pkg::PH_TRAILER: cmd.idx_clr    = take && st.trailer_hit;
			spd_pkg::PH_EMIT_RD: cmd.rd_en      = 1'b1;
			spd_pkg::PH_EMIT_LD: begin
				cmd.ld_out  = st.out_free;
				cmd.idx_inc = st.out_free && !st.last_item;
			end
		endcase
	end

endmodule

// File: rtl/core/spd_dp.sv
module spd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spd_pkg::BYTE_W-1:0]        cfg_wdata,
	input  logic [spd_pkg::BYTE_W-1:0]        rx_byte,
	input  spd_pkg::spd_cmd_t                 cmd,
	output spd_pkg::spd_stat_t                st,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spd_pkg::OUT_TDATA_W-1:0]   out_data,
	output logic                              out_last
);

	logic [spd_pkg::BYTE_W-1:0] sync_first_q, sync_second_q, trailer_q;
	logic [spd_pkg::LEN_W-1:0]  length_limit_q;

	logic [spd_pkg::BYTE_W-1:0] held_sync_first_q, held_sync_second_q, held_type_q;
	logic [spd_pkg::LEN_W-1:0]  held_length_q;
	logic [spd_pkg::LEN_W-1:0]  pay_count_q;
	logic [spd_pkg::IDX_W-1:0]  rd_idx_q;

	logic                             out_valid_q;
	logic [spd_pkg::OUT_TDATA_W-1:0]  out_data_q;
	logic                             out_last_q;

	logic [spd_pkg::BYTE_W-1:0] ram_q;
	logic                       ram_we;
	logic                       has_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= spd_pkg::SYNC_FIRST_RST;
			sync_second_q  <= spd_pkg::SYNC_SECOND_RST;
			trailer_q      <= spd_pkg::TRAILER_RST;
			length_limit_q <= spd_pkg::LENGTH_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spd_pkg::REG_SYNC_FIRST:   sync_first_q   <= cfg_wdata;
				spd_pkg::REG_SYNC_SECOND:  sync_second_q  <= cfg_wdata;
				spd_pkg::REG_TRAILER:      trailer_q      <= cfg_wdata;
				spd_pkg::REG_LENGTH_LIMIT: length_limit_q <= cfg_wdata[spd_pkg::LEN_W-1:0];
			endcase
		end
	end

	// Header fields.
	always_ff @(posedge clk) begin
		if (cmd.cap_sync1)  held_sync_first_q  <= rx_byte;
		if (cmd.cap_sync2)  held_sync_second_q <= rx_byte;
		if (cmd.cap_type)   held_type_q        <= rx_byte;
		if (cmd.cap_length) held_length_q      <= rx_byte[spd_pkg::LEN_W-1:0];
	end

	// Payload write counter and drain read index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_count_q <= '0;
			rd_idx_q    <= '0;
		end else begin
			if (cmd.cap_length) pay_count_q <= '0;
			else if (cmd.pay_wr) pay_count_q <= pay_count_q + spd_pkg::LEN_W'(1);
			if (cmd.idx_clr) rd_idx_q <= '0;
			else if (cmd.idx_inc) rd_idx_q <= rd_idx_q + spd_pkg::IDX_W'(1);
		end
	end

	assign ram_we = cmd.pay_wr && (pay_count_q < spd_pkg::LEN_W'(spd_pkg::PAYLOAD_MAX));

	spd_ram #(
		.WIDTH (spd_pkg::BYTE_W),
		.DEPTH (spd_pkg::PAYLOAD_MAX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pay_count_q[spd_pkg::IDX_W-1:0]),
		.wdata (rx_byte),
		.re    (cmd.rd_en),
		.raddr (rd_idx_q),
		.rdata (ram_q)
	);

	// Status towards the controller.
	assign st.sync_hit    = (rx_byte == sync_first_q);
	assign st.hdr_ok      = (held_sync_first_q == sync_first_q)
		&& ((held_sync_second_q & spd_pkg::SYNC_SECOND_MASK) == sync_second_q)
		&& (rx_byte <= spd_pkg::BYTE_W'(length_limit_q))
		&& (rx_byte <= spd_pkg::BYTE_W'(spd_pkg::PAYLOAD_MAX));
	assign st.len_zero    = (rx_byte == '0);
	assign st.pay_done    = ((pay_count_q + spd_pkg::LEN_W'(1)) == held_length_q);
	assign st.trailer_hit = (rx_byte == trailer_q);
	assign st.held_zero   = (held_length_q == '0);
	assign st.last_item   = st.held_zero
		|| ((spd_pkg::LEN_W'(rd_idx_q) + spd_pkg::LEN_W'(1)) == held_length_q);
	assign st.out_free    = !out_valid_q || out_ready;

	// Output register.
	assign has_data = !st.held_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_data_q <= {
				{spd_pkg::OUT_PAD_W{1'b0}},
				(has_data ? ram_q : {spd_pkg::BYTE_W{1'b0}}),
				rd_idx_q,
				has_data,
				held_sync_second_q[0],
				held_length_q,
				held_type_q
			};
			out_last_q <= st.last_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// File: rtl/core/serial_packet_deframer.sv
// Serial packet deframer. Each input item is one byte from a serial link; the block hunts for
// frames made of a first sync byte, a second sync byte whose bit 0 asks for an acknowledge, a
// type byte, a length byte, that many payload bytes and a trailer byte. The header is checked
// when the length byte arrives (both sync bytes against their registers, the length against
// length_limit and the 32-byte store), and a failed check returns the receiver to hunting without
// looking at that byte again. Payload bytes go into a 32-entry store; a matching trailer then
// releases the frame as a run of output items, one per payload byte with tlast on the final one,
// or a single item without data for an empty frame. A wrong trailer drops the frame silently.
// While receiving, one byte is taken each clock cycle. After a good trailer the input is held
// off while the frame is read back: the store has a registered read port, so each result takes
// a read and then a load into the output register. For an empty frame only the load is made,
// with no read. A stalled output register stretches each load until it is free. The last result
// may still wait in the output register while the next frame is being received. The store holds
// no reset value and needs no clearing pass, since only entries written for the current frame
// are read. Configuration must be written only while no frame is in progress.
module serial_packet_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	// Received bytes.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [spd_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
	// Frame results.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] frame_type, [13:8] frame_length, [14] ack_wanted, [15] has_data,
	// [20:16] byte_index, [28:21] data_byte, [31:29] zero
	output logic [spd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	// Configuration writes.
	input  logic                              cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spd_pkg::BYTE_W-1:0]        cfg_wdata
);

`include "serial_packet_deframer_macros.svh"

	spd_pkg::spd_cmd_t  cmd;
	spd_pkg::spd_stat_t st;

	// The controller sequences the header, payload, trailer and read-back phases.
	spd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the registers, header fields, payload store and output register.
	spd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	// A new result is only loaded when the output register is free or being emptied.
	`SPD_ASSERT_NOW(a_load_into_free, cmd.ld_out, st.out_free)
	// A store read is always followed by a load attempt, with the input still stalled.
	`SPD_ASSERT_NEXT(a_read_then_load, cmd.rd_en, !s_tready)
	// A result without data is the single result of an empty frame.
	`SPD_ASSERT_NOW(a_empty_frame_item, m_tvalid && !m_tdata[15],
		m_tlast && (m_tdata[13:8] == '0) && (m_tdata[28:16] == '0))
	// Payload writes and store reads never happen together.
	`SPD_ASSERT_NOW(a_write_read_apart, cmd.pay_wr, !cmd.rd_en && !cmd.ld_out)

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import spd_pkg::*;

	// A generous ceiling on the run. Even if every item raised a full 32-byte frame and every
	// result sat out the longest receiver stall, the run would finish well inside it.
	localparam int CYCLE_LIMIT     = 4000000;
	// Slowest frame release: a read and a load per byte plus the output register, with some margin.
	localparam int DRAIN_CYCLES    = 2 * PAYLOAD_MAX + 16;
	// The long stretch in which the receiver refuses items while bytes keep being offered.
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int RANDOM_PHASES   = 7;
	localparam int ITEMS_PER_PHASE = 36;

	// One frame result, as carried in m_tdata and m_tlast.
	typedef struct packed {
		logic [BYTE_W-1:0] frame_type;
		logic [LEN_W-1:0]  frame_length;
		logic              ack_wanted;
		logic              has_data;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} frame_item_t;

	// A row of the directed table: a byte whose results come from the predictor, a byte whose
	// single result is typed in beside it, or a register write made once the block is idle.
	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_CHECKED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		cfg_reg_t          sel;
		logic [BYTE_W-1:0] value;
		frame_item_t       want;
	} stim_row_t;

	localparam frame_item_t NO_ITEM = '0;

	// The directed part runs with the reset register values until the write near its end.
	localparam stim_row_t DIRECTED [24] = '{
		// An empty frame that asks for an acknowledge, with the all-ones type byte nowhere
		// near: it gives exactly one result without data and with last set.
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h55, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'hAB, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h07, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h00, NO_ITEM},
		'{ROW_CHECKED, REG_SYNC_FIRST,  8'h45,
			'{8'h07, 6'd0, 1'b1, 1'b0, 5'd0, 8'h00, 1'b1}},
		// The length byte equals the first sync byte and is far above the limit. The header
		// is rejected and that byte must not start a new frame, so the rest is skipped.
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h55, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'hAA, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h00, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h55, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'hAA, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h03, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h00, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h45, NO_ITEM},
		// An empty frame with the largest type byte and a wrong trailer is dropped silently.
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h55, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'hAA, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'hFF, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h00, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h44, NO_ITEM},
		// With bit 0 set in the second sync register no header can ever match.
		'{ROW_CFG,     REG_SYNC_SECOND, 8'hAB, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h55, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'hAB, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h01, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h00, NO_ITEM},
		'{ROW_BYTE,    REG_SYNC_FIRST,  8'h45, NO_ITEM}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [BYTE_W-1:0]      cfg_wdata;

	serial_packet_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// The testbench's own copy of the registers and of the receiver state.
	logic [BYTE_W-1:0] cfg_sync1;
	logic [BYTE_W-1:0] cfg_sync2;
	logic [BYTE_W-1:0] cfg_trailer;
	logic [LEN_W-1:0]  cfg_limit;
	phase_t            rx_state;
	logic [BYTE_W-1:0] held_sync1;
	logic [BYTE_W-1:0] held_sync2;
	logic [BYTE_W-1:0] held_type;
	logic [LEN_W-1:0]  held_len;
	logic [LEN_W-1:0]  pay_count;
	logic [BYTE_W-1:0] pay_store [PAYLOAD_MAX];

	// Results raised by the byte just accepted, and results still owed by the block.
	frame_item_t fresh_items [$];
	frame_item_t frames_due [$];

	int mismatches;
	int cycle_count;
	// When set, neither side idles.
	bit steady;
	// Asks the receiver for one long hold-off.
	bit hold_off_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A short gap most of the time, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < 40)
			$display("mismatch at cycle %0d: %s got %0h, expected %0h", cycle_count, what,
				got, want);
		mismatches++;
	endtask

	// Advances the predicted receiver by one byte, leaving any released frame in fresh_items.
	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		frame_item_t it;
		int n;
		case (rx_state)
			PH_SYNC1: begin
				held_sync2 = b;
				rx_state = PH_SYNC2;
			end
			PH_SYNC2: begin
				held_type = b;
				rx_state = PH_TYPE;
			end
			PH_TYPE: begin
				// The header is judged as a whole once the length byte is here.
				if (held_sync1 != cfg_sync1 || (held_sync2 & SYNC_SECOND_MASK) != cfg_sync2 ||
					b > cfg_limit || b > PAYLOAD_MAX) begin
					rx_state = PH_IDLE;
				end else begin
					held_len = b[LEN_W-1:0];
					pay_count = '0;
					if (held_len == 0)
						rx_state = PH_TRAILER;
					else
						rx_state = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pay_count < PAYLOAD_MAX)
					pay_store[pay_count[IDX_W-1:0]] = b;
				pay_count = pay_count + LEN_W'(1);
				if (pay_count == held_len)
					rx_state = PH_TRAILER;
			end
			PH_TRAILER: begin
				if (b == cfg_trailer) begin
					n = int'(held_len);
					it.frame_type = held_type;
					it.ack_wanted = held_sync2[0];
					if (n == 0) begin
						it.frame_length = '0;
						it.has_data = 1'b0;
						it.byte_index = '0;
						it.data_byte = '0;
						it.last = 1'b1;
						fresh_items.push_back(it);
					end else begin
						for (int i = 0; i < n; i++) begin
							it.frame_length = held_len;
							it.has_data = 1'b1;
							it.byte_index = i[IDX_W-1:0];
							it.data_byte = pay_store[i[IDX_W-1:0]];
							it.last = (i + 1 == n);
							fresh_items.push_back(it);
						end
					end
				end
				rx_state = PH_IDLE;
			end
			default: begin
				// Hunting: anything but the first sync byte is passed over.
				held_sync1 = b;
				if (b == cfg_sync1)
					rx_state = PH_SYNC1;
				else
					rx_state = PH_IDLE;
			end
		endcase
	endtask

	// Offers one byte after a random gap and waits until it is taken. The expected results
	// are queued at the edge of acceptance, before the block can possibly present them.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
		input frame_item_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		fresh_items.delete();
		deframe_byte(b);
		if (typed)
			frames_due.push_back(want);
		else
			foreach (fresh_items[k])
				frames_due.push_back(fresh_items[k]);
	endtask

	task automatic send_plain(input logic [BYTE_W-1:0] b);
		send_byte(b, 1'b0, NO_ITEM);
	endtask

	// Stops offering, waits for every owed result and then for the longest frame release, so
	// that a register write cannot land while the block is still busy.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [BYTE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_SYNC_FIRST:   cfg_sync1 = v;
			REG_SYNC_SECOND:  cfg_sync2 = v;
			REG_TRAILER:      cfg_trailer = v;
			REG_LENGTH_LIMIT: cfg_limit = v[LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Mostly well-formed frames with random content under the current registers, with a share
	// of broken headers, out-of-range lengths, wrong trailers and loose noise bytes. Only the
	// bytes of frames are counted.
	task automatic send_random_traffic(input int n_items);
		int sent;
		int r;
		int max_len;
		int pay_len;
		logic [BYTE_W-1:0] len_byte;
		sent = 0;
		max_len = (cfg_limit < PAYLOAD_MAX) ? int'(cfg_limit) : PAYLOAD_MAX;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				send_plain(BYTE_W'($urandom_range(0, 255)));
			end else begin
				if (r < 19)
					send_plain(BYTE_W'($urandom_range(0, 255)));
				else
					send_plain(cfg_sync1);
				if (r < 23)
					send_plain(BYTE_W'($urandom_range(0, 255)));
				else
					send_plain(cfg_sync2 | BYTE_W'($urandom_range(0, 1)));
				send_plain(BYTE_W'($urandom_range(0, 255)));
				// Short frames for the most part, full-size ones only now and then.
				r = $urandom_range(0, 99);
				if (r < 45)
					len_byte = BYTE_W'($urandom_range(0, 3));
				else if (r < 75)
					len_byte = BYTE_W'($urandom_range(4, 10));
				else if (r < 85)
					len_byte = BYTE_W'(max_len);
				else if (r < 93)
					len_byte = BYTE_W'($urandom_range(0, max_len));
				else
					len_byte = BYTE_W'($urandom_range(0, 255));
				send_plain(len_byte);
				pay_len = (len_byte > PAYLOAD_MAX) ? int'($urandom_range(0, 4)) : int'(len_byte);
				for (int i = 0; i < pay_len; i++)
					send_plain(BYTE_W'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) == 0)
					send_plain(BYTE_W'($urandom_range(0, 255)));
				else
					send_plain(cfg_trailer);
				sent += pay_len + 5;
			end
		end
	endtask

	// Compares one accepted result with the oldest one owed.
	task automatic check_frame_item();
		frame_item_t want;
		if (frames_due.size() == 0) begin
			report_mismatch("result with nothing expected", m_tdata, '0);
			return;
		end
		want = frames_due.pop_front();
		if (m_tdata[7:0] != want.frame_type)
			report_mismatch("frame_type", 32'(m_tdata[7:0]), 32'(want.frame_type));
		if (m_tdata[13:8] != want.frame_length)
			report_mismatch("frame_length", 32'(m_tdata[13:8]), 32'(want.frame_length));
		if (m_tdata[14] != want.ack_wanted)
			report_mismatch("ack_wanted", 32'(m_tdata[14]), 32'(want.ack_wanted));
		if (m_tdata[15] != want.has_data)
			report_mismatch("has_data", 32'(m_tdata[15]), 32'(want.has_data));
		if (m_tdata[20:16] != want.byte_index)
			report_mismatch("byte_index", 32'(m_tdata[20:16]), 32'(want.byte_index));
		if (m_tdata[28:21] != want.data_byte)
			report_mismatch("data_byte", 32'(m_tdata[28:21]), 32'(want.data_byte));
		if (m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] != '0)
			report_mismatch("padding", 32'(m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]), '0);
		if (m_tlast != want.last)
			report_mismatch("last", 32'(m_tlast), 32'(want.last));
	endtask

	// Receiver: takes results with random stalls, and once holds off for a long stretch that
	// it counts out itself, so that the block fills up and refuses input meanwhile.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_frame_item();
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("serial_packet_deframer test failed");
		$finish;
	end

	initial begin
		logic [BYTE_W-1:0] v_sync1;
		logic [BYTE_W-1:0] v_sync2;
		logic [BYTE_W-1:0] v_trailer;
		logic [BYTE_W-1:0] v_limit;
		mismatches = 0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SYNC_FIRST;
		cfg_wdata <= '0;

		// Predicted state after reset.
		cfg_sync1 = SYNC_FIRST_RST;
		cfg_sync2 = SYNC_SECOND_RST;
		cfg_trailer = TRAILER_RST;
		cfg_limit = LENGTH_LIMIT_RST;
		rx_state = PH_IDLE;
		held_sync1 = '0;
		held_sync2 = '0;
		held_type = '0;
		held_len = '0;
		pay_count = '0;
		foreach (pay_store[i])
			pay_store[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			case (DIRECTED[i].kind)
				ROW_CHECKED: send_byte(DIRECTED[i].value, 1'b1, DIRECTED[i].want);
				ROW_CFG: begin
					wait_for_drain();
					write_reg(DIRECTED[i].sel, DIRECTED[i].value);
				end
				default: send_plain(DIRECTED[i].value);
			endcase
		end

		// Random phases, each under its own register setting. Between phases the sender
		// pauses until every owed result has arrived.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					v_sync1 = SYNC_FIRST_RST;
					v_sync2 = SYNC_SECOND_RST;
					v_trailer = TRAILER_RST;
					v_limit = BYTE_W'(LENGTH_LIMIT_RST);
				end
				1: begin
					// Lowest values: only empty frames can pass.
					v_sync1 = 8'h00;
					v_sync2 = 8'h00;
					v_trailer = 8'h00;
					v_limit = 8'h00;
				end
				2: begin
					v_sync1 = 8'hFF;
					v_sync2 = 8'hFE;
					v_trailer = 8'hFF;
					v_limit = BYTE_W'(PAYLOAD_MAX);
				end
				3: begin
					// The limit reads as 63, above the store, which still caps the length.
					v_sync1 = SYNC_FIRST_RST;
					v_sync2 = SYNC_SECOND_RST;
					v_trailer = TRAILER_RST;
					v_limit = 8'hFF;
				end
				default: begin
					v_sync1 = BYTE_W'($urandom_range(0, 255));
					v_sync2 = BYTE_W'($urandom_range(0, 255)) & SYNC_SECOND_MASK;
					v_trailer = BYTE_W'($urandom_range(0, 255));
					v_limit = BYTE_W'($urandom_range(1, PAYLOAD_MAX));
				end
			endcase
			wait_for_drain();
			write_reg(REG_SYNC_FIRST, v_sync1);
			write_reg(REG_SYNC_SECOND, v_sync2);
			write_reg(REG_TRAILER, v_trailer);
			write_reg(REG_LENGTH_LIMIT, v_limit);
			steady = (ph == 2 || ph == 5);
			if (ph == 0)
				hold_off_req = 1'b1;
			send_random_traffic(ITEMS_PER_PHASE);
		end

		wait_for_drain();
		if (mismatches == 0 && frames_due.size() == 0)
			$display("serial_packet_deframer test passed");
		else
			$display("serial_packet_deframer test failed");
		$finish;
	end

endmodule
